[design/c_source_token_lexer_unit_macros.svh]
// Assertion macros for the C source token lexer.
// Define ASSERT_OFF to compile them out; no other dependencies.
`ifndef C_SOURCE_TOKEN_LEXER_UNIT_MACROS_SVH
`define C_SOURCE_TOKEN_LEXER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CSTL_ASSERT_IMP(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

// next-cycle implication
`define CSTL_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("lexer assertion failed");

`else

`define CSTL_ASSERT_IMP(name, clock, reset, ante, cons)
`define CSTL_ASSERT_NEXT(name, clock, reset, ante, cons)

`endif

`endif

[design/cstl_pkg.sv]
// Shared types, codes and character classes for the C source token lexer.
// No dependencies; used by the step logic and the top level.
package cstl_pkg;

  localparam int POSITION_WIDTH_DEFAULT = 16;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_OPER,
    MODE_ZERO,
    MODE_OCT,
    MODE_HEX,
    MODE_DEC,
    MODE_IDENT,
    MODE_CHAR,
    MODE_STR
  } mode_t;

  typedef enum logic [2:0] {
    CLASS_SPACE,
    CLASS_OPERATOR,
    CLASS_NUMBER,
    CLASS_IDENT,
    CLASS_PUNCT,
    CLASS_CHAR,
    CLASS_STRING
  } tok_class_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_UNKNOWN,
    ERR_DOT,
    ERR_EXPONENT,
    ERR_UNTERMINATED
  } lex_err_t;

  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Lexer state apart from the line and column counters
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  op_first;
    logic [7:0]  op_second;
    logic [1:0]  op_len;
    logic        dot_seen;
    logic        exp_seen;
    logic        prior_bs;
    lex_err_t    error;
  } lex_state_t;

  localparam lex_state_t LEX_STATE_RESET = '{
    mode: MODE_IDLE, op_first: 8'h00, op_second: 8'h00, op_len: 2'd0,
    dot_seen: 1'b0, exp_seen: 1'b0, prior_bs: 1'b0, error: ERR_NONE
  };

  // Per-byte label, positions travel separately
  typedef struct packed {
    tok_class_t  token_class;
    logic        token_begins;
    lex_err_t    error;
  } lex_result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_label(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] u;
    u = to_upper(c);
    return is_digit(c) || (u >= "A" && u <= "F");
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic is_suffix(input logic [7:0] c);
    logic [7:0] u;
    u = to_upper(c);
    return u == "F" || u == "L" || u == "U";
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == "{" || c == "}" || c == "(" || c == ")" ||
           c == "[" || c == "]" || c == ";" || c == ",";
  endfunction

  // single-byte operators: / * - + : ? % ^ ! & | = ~ . > <
  function automatic logic is_op_char(input logic [7:0] c);
    return c == "/" || c == "*" || c == "-" || c == "+" || c == ":" || c == "?" ||
           c == "%" || c == "^" || c == "!" || c == "&" || c == "|" || c == "=" ||
           c == "~" || c == "." || c == ">" || c == "<";
  endfunction

  // two-byte operators, given the first byte a and the new byte c
  function automatic logic op_pair_ok(input logic [7:0] a, input logic [7:0] c);
    return (a == "+" && (c == "+" || c == "=")) ||
           (a == "-" && (c == "-" || c == ">" || c == "=")) ||
           (a == "<" && (c == "<" || c == "=")) ||
           (a == ">" && (c == ">" || c == "=")) ||
           (a == "&" && (c == "&" || c == "=")) ||
           (a == "|" && (c == "|" || c == "=")) ||
           ((a == "=" || a == "!" || a == "*" || a == "/" || a == "%" || a == "^")
            && c == "=");
  endfunction

  // three-byte operators: shift-assign only
  function automatic logic op_triple_ok(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    return a == b && (a == "<" || a == ">") && c == "=";
  endfunction

  function automatic logic op_extends(input logic [1:0] len, input logic [7:0] a,
                                      input logic [7:0] b, input logic [7:0] c);
    logic ok;
    case (len)
      2'd1:    ok = op_pair_ok(a, c);
      2'd2:    ok = op_triple_ok(a, b, c);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

[design/cstl_if.sv]
// Valid/ready channels of the C source token lexer: source bytes in, labels out.
// No dependencies.
interface cstl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_char;
  logic       final_char;

  modport source (output valid, source_char, final_char, input ready);
  modport sink   (input valid, source_char, final_char, output ready);
endinterface

interface cstl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_class;
  logic        token_begins;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic [2:0]  lex_error;

  modport source (output valid, token_class, token_begins, line_number,
                  column_number, lex_error, input ready);
  modport sink   (input valid, token_class, token_begins, line_number,
                  column_number, lex_error, output ready);
endinterface

[design/c_source_token_lexer_unit.sv]
// Top level of the C source token lexer: input register, step logic, result register.
// Depends on cstl_pkg, cstl_if.sv, cstl_lex_step and the assertion macro header.
`include "c_source_token_lexer_unit_macros.svh"

// The lexer takes one source byte per transfer and returns one label per byte
// (token class, token-start mark, line, column, sticky error), in order. It
// sustains one byte per clock while the label output is not stalled: each
// byte's label and the lexer's next state come from one combinational step
// on a small mode register, so throughput is set by that one step. A byte
// passes through the input register, then the result register, before its
// label is offered, and a stalled result does not hold up the input side
// until both registers are full. After a byte marked final the lexer
// returns to its reset state. No memories and no start-up clearing pass.
module c_source_token_lexer_unit
  import cstl_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  cstl_in_if.sink     chars,
  cstl_out_if.source  tokens
);

  localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

  // input register
  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_fin;

  // lexer state
  lex_state_t                state;
  logic [POSITION_WIDTH-1:0] line;
  logic [POSITION_WIDTH-1:0] col;

  // step outputs
  lex_state_t                state_next;
  logic [POSITION_WIDTH-1:0] line_next;
  logic [POSITION_WIDTH-1:0] col_next;
  lex_result_t               step_result;
  logic [15:0]               step_line;
  logic [15:0]               step_col;

  // result register
  logic        out_valid;
  lex_result_t out_result;
  logic [15:0] out_line;
  logic [15:0] out_col;

  logic advance;

  assign advance     = !out_valid || tokens.ready;
  assign chars.ready = !s1_valid || advance;

  cstl_lex_step #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_step (
    .st        (state),
    .line      (line),
    .col       (col),
    .ch        (s1_char),
    .fin       (s1_fin),
    .st_next   (state_next),
    .line_next (line_next),
    .col_next  (col_next),
    .result    (step_result),
    .line_out  (step_line),
    .col_out   (step_col)
  );

  // Control and lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= LEX_STATE_RESET;
      line      <= POS_ONE;
      col       <= '0;
    end else begin
      if (chars.ready) s1_valid <= chars.valid;
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          state <= state_next;
          line  <= line_next;
          col   <= col_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char <= chars.source_char;
      s1_fin  <= chars.final_char;
    end
    if (advance && s1_valid) begin
      out_result <= step_result;
      out_line   <= step_line;
      out_col    <= step_col;
    end
  end

  assign tokens.valid         = out_valid;
  assign tokens.token_class   = out_result.token_class;
  assign tokens.token_begins  = out_result.token_begins;
  assign tokens.line_number   = out_line;
  assign tokens.column_number = out_col;
  assign tokens.lex_error     = out_result.error;

  // a stage that cannot move keeps its byte
  `CSTL_ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !advance, s1_valid)
  // a token start is never labelled as space
  `CSTL_ASSERT_IMP(a_begin_class, clk, rst, out_valid && out_result.token_begins,
                   out_result.token_class != CLASS_SPACE)
  // positions count from one
  `CSTL_ASSERT_IMP(a_pos_nonzero, clk, rst, out_valid,
                   out_line != 16'd0 && out_col != 16'd0)
  // a latched error survives every byte but the last
  `CSTL_ASSERT_NEXT(a_error_sticky, clk, rst,
                    advance && s1_valid && !s1_fin && state.error != ERR_NONE,
                    state.error == $past(state.error))
  // the last byte of a source puts the lexer back to its reset state
  `CSTL_ASSERT_NEXT(a_final_resets, clk, rst, advance && s1_valid && s1_fin,
                    state == LEX_STATE_RESET && line == POS_ONE && col == '0)

endmodule

[design/cstl_lex_step.sv]
// One lexing step: labels a byte and works out the next lexer state.
// Purely combinational; depends on cstl_pkg.
module cstl_lex_step
  import cstl_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
  input  lex_state_t                st,
  input  logic [POSITION_WIDTH-1:0] line,
  input  logic [POSITION_WIDTH-1:0] col,
  input  logic [7:0]                ch,
  input  logic                      fin,
  output lex_state_t                st_next,
  output logic [POSITION_WIDTH-1:0] line_next,
  output logic [POSITION_WIDTH-1:0] col_next,
  output lex_result_t               result,
  output logic [15:0]               line_out,
  output logic [15:0]               col_out
);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
  localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

  logic        cont;
  logic        num_end;
  logic        suffix_hit;
  tok_class_t  cont_cls;
  lex_err_t    cont_err;
  tok_class_t  start_cls;
  logic        start_beg;
  mode_t       start_mode;
  lex_err_t    start_err;
  lex_err_t    err_code;
  lex_err_t    error_next;
  logic [POSITION_WIDTH-1:0] col_inc;
  logic [31:0] line_wide;
  logic [31:0] col_wide;

  // Does the byte continue the open token?
  always_comb begin
    cont     = 1'b0;
    num_end  = 1'b0;
    cont_cls = CLASS_SPACE;
    cont_err = ERR_NONE;
    case (st.mode)
      MODE_OPER: begin
        cont_cls = CLASS_OPERATOR;
        cont     = op_extends(st.op_len, st.op_first, st.op_second, ch);
      end
      MODE_ZERO: begin
        cont_cls = CLASS_NUMBER;
        cont     = (ch == "x") || is_oct(ch);
        num_end  = !cont;
      end
      MODE_OCT: begin
        cont_cls = CLASS_NUMBER;
        cont     = is_oct(ch);
        num_end  = !cont;
      end
      MODE_HEX: begin
        cont_cls = CLASS_NUMBER;
        cont     = is_hex(ch);
        num_end  = !cont;
      end
      MODE_DEC: begin
        cont_cls = CLASS_NUMBER;
        if (ch == ".") begin
          cont = 1'b1;
          if (st.dot_seen) cont_err = ERR_DOT;
        end else if (to_upper(ch) == "E") begin
          cont = 1'b1;
          if (st.exp_seen) cont_err = ERR_EXPONENT;
        end else if (is_digit(ch)) begin
          cont = 1'b1;
        end else begin
          num_end = 1'b1;
        end
      end
      MODE_IDENT: begin
        cont_cls = CLASS_IDENT;
        cont     = is_label(ch);
      end
      MODE_CHAR: begin
        cont_cls = CLASS_CHAR;
        cont     = 1'b1;
      end
      MODE_STR: begin
        cont_cls = CLASS_STRING;
        cont     = 1'b1;
      end
      default: begin
        cont = 1'b0;
      end
    endcase
    // one F/L/U byte closes a number
    suffix_hit = num_end && is_suffix(ch);
    if (suffix_hit) begin
      cont     = 1'b1;
      cont_cls = CLASS_NUMBER;
    end
  end

  // What token would this byte open?
  always_comb begin
    start_cls  = CLASS_SPACE;
    start_beg  = 1'b1;
    start_mode = MODE_IDLE;
    start_err  = ERR_NONE;
    if (is_space(ch)) begin
      start_beg = 1'b0;
    end else if (is_op_char(ch)) begin
      start_cls  = CLASS_OPERATOR;
      start_mode = MODE_OPER;
    end else if (ch == "0") begin
      start_cls  = CLASS_NUMBER;
      start_mode = MODE_ZERO;
    end else if (is_digit(ch)) begin
      start_cls  = CLASS_NUMBER;
      start_mode = MODE_DEC;
    end else if (is_alpha(ch) || ch == "_") begin
      start_cls  = CLASS_IDENT;
      start_mode = MODE_IDENT;
    end else if (is_punct(ch)) begin
      start_cls  = CLASS_PUNCT;
    end else if (ch == CH_QUOTE) begin
      start_cls  = CLASS_CHAR;
      start_mode = MODE_CHAR;
    end else if (ch == CH_DQUOTE) begin
      start_cls  = CLASS_STRING;
      start_mode = MODE_STR;
    end else begin
      start_beg = 1'b0;
      start_err = ERR_UNKNOWN;
    end
  end

  // Next lexer state; the first error sticks until the source ends
  always_comb begin
    st_next = st;
    if (cont) begin
      case (st.mode)
        MODE_OPER: begin
          if (st.op_len == 2'd1) st_next.op_second = ch;
          st_next.op_len = st.op_len + 2'd1;
        end
        MODE_ZERO: st_next.mode = (ch == "x") ? MODE_HEX : MODE_OCT;
        MODE_DEC: begin
          if (ch == ".") st_next.dot_seen = 1'b1;
          else if (to_upper(ch) == "E") st_next.exp_seen = 1'b1;
        end
        MODE_CHAR: begin
          if (ch == CH_QUOTE && !st.prior_bs) st_next.mode = MODE_IDLE;
          st_next.prior_bs = (ch == CH_BSLASH);
        end
        MODE_STR: begin
          if (ch == CH_DQUOTE && !st.prior_bs) st_next.mode = MODE_IDLE;
          st_next.prior_bs = (ch == CH_BSLASH);
        end
        default: st_next.mode = st.mode;
      endcase
      if (suffix_hit) st_next.mode = MODE_IDLE;
    end else begin
      st_next.mode = start_mode;
      case (start_mode)
        MODE_OPER: begin
          st_next.op_first = ch;
          st_next.op_len   = 2'd1;
        end
        MODE_DEC: begin
          st_next.dot_seen = 1'b0;
          st_next.exp_seen = 1'b0;
        end
        MODE_CHAR, MODE_STR: st_next.prior_bs = 1'b0;
        default: st_next.prior_bs = st.prior_bs;
      endcase
    end

    err_code = cont ? cont_err : start_err;
    if (fin && (st_next.mode == MODE_CHAR || st_next.mode == MODE_STR))
      err_code = ERR_UNTERMINATED;
    error_next    = (st.error == ERR_NONE) ? err_code : st.error;
    st_next.error = error_next;

    // end of source: start afresh
    if (fin) st_next = LEX_STATE_RESET;
  end

  // Label for this byte
  always_comb begin
    result.token_class  = cont ? cont_cls : start_cls;
    result.token_begins = !cont && start_beg;
    result.error        = error_next;
  end

  // Line and column, saturating; a newline belongs to the line it ends
  always_comb begin
    col_inc   = (col != POS_MAX) ? col + POS_ONE : col;
    line_wide = 32'(line);
    col_wide  = 32'(col_inc);
    line_out  = (|line_wide[31:16]) ? 16'hFFFF : line_wide[15:0];
    col_out   = (|col_wide[31:16]) ? 16'hFFFF : col_wide[15:0];
    line_next = line;
    col_next  = col_inc;
    if (ch == CH_NEWLINE) begin
      if (line != POS_MAX) line_next = line + POS_ONE;
      col_next = '0;
    end
    if (fin) begin
      line_next = POS_ONE;
      col_next  = '0;
    end
  end

endmodule
